// ----- design/dnc_pkg.sv -----
// Shared types, constants and calendar tables for the date and day number converter.
package dnc_pkg;

  localparam logic [5:0]  ASCII_ZERO   = 6'd48;
  localparam logic [7:0]  YEAR_CHAR_LO = 8'd50;
  localparam logic [7:0]  YEAR_CHAR_HI = 8'd56;
  localparam logic [11:0] LAST_DAY     = 12'd2557;
  localparam logic [11:0] DIGIT_BIAS   = 12'd528;
  localparam logic [11:0] MONTH_LO_RAW = 12'd529;
  localparam logic [11:0] MONTH_HI_RAW = 12'd541;
  localparam logic [3:0]  FIRST_MONTH  = 4'd1;
  localparam logic [3:0]  LAST_MONTH   = 4'd12;
  localparam logic [3:0]  MONTH_ALL    = 4'd13;
  localparam logic [2:0]  LEAP_IDX_A   = 3'd0;
  localparam logic [2:0]  LEAP_IDX_B   = 3'd4;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] year_idx;
    logic       leap;
    logic [8:0] doy;
  } ysplit_t;

  typedef struct packed {
    logic        cmd;
    logic        enc_ok;
    logic [11:0] enc_days;
    ysplit_t     ys;
  } mid_t;

  // Days before the first day of year 1992 + idx.
  function automatic logic [11:0] year_start(input logic [2:0] idx);
    logic [11:0] v;
    unique case (idx)
      3'd0:    v = 12'd0;
      3'd1:    v = 12'd366;
      3'd2:    v = 12'd731;
      3'd3:    v = 12'd1096;
      3'd4:    v = 12'd1461;
      3'd5:    v = 12'd1827;
      3'd6:    v = 12'd2192;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

  // Days in the year before the first day of month idx; month 13 gives the year length.
  function automatic logic [8:0] month_cum(input logic leap, input logic [3:0] idx);
    logic [8:0] v;
    unique case (idx)
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      4'd13:   v = 9'd365;
      default: v = 9'd0;
    endcase
    if (leap && idx >= 4'd3 && idx <= 4'd13) begin
      v = v + 9'd1;
    end
    return v;
  endfunction

endpackage

// ----- design/dnc_encode.sv -----
// Date digits to day number conversion.
module dnc_encode (
  input  logic [7:0]  year_char,
  input  logic [7:0]  month_tens_char,
  input  logic [7:0]  month_ones_char,
  input  logic [7:0]  day_tens_char,
  input  logic [7:0]  day_ones_char,
  output logic        enc_ok,
  output logic [11:0] enc_days
);
  import dnc_pkg::*;

  logic [11:0] mm_raw;
  logic [11:0] dd_raw;
  logic [2:0]  yoff;
  logic        leap;
  logic [3:0]  midx;
  logic [11:0] mid_diff;
  logic [11:0] sum;

  always_comb begin
    mm_raw = {1'b0, month_tens_char, 3'b000} + {3'b000, month_tens_char, 1'b0}
           + {4'd0, month_ones_char};
    dd_raw = {1'b0, day_tens_char, 3'b000} + {3'b000, day_tens_char, 1'b0}
           + {4'd0, day_ones_char};
    enc_ok = (year_char >= YEAR_CHAR_LO) && (year_char <= YEAR_CHAR_HI);
    yoff   = 3'(year_char - YEAR_CHAR_LO);
    leap   = (yoff == LEAP_IDX_A) || (yoff == LEAP_IDX_B);
    mid_diff = mm_raw - DIGIT_BIAS;
    priority if (mm_raw <= MONTH_LO_RAW) begin
      midx = FIRST_MONTH;
    end else if (mm_raw >= MONTH_HI_RAW) begin
      midx = MONTH_ALL;
    end else begin
      midx = mid_diff[3:0];
    end
    sum = dd_raw - DIGIT_BIAS + year_start(yoff) + {3'd0, month_cum(leap, midx)};
    enc_days = enc_ok ? sum : 12'd0;
  end

endmodule

// ----- design/dnc_year_split.sv -----
// Day number to year and day of year split.
module dnc_year_split (
  input  logic [11:0]     day_number,
  output dnc_pkg::ysplit_t ys
);
  import dnc_pkg::*;

  logic [2:0]  idx;
  logic [11:0] diff;

  always_comb begin
    idx = 3'd0;
    for (int i = 1; i < 7; i++) begin
      if (day_number > year_start(3'(i))) begin
        idx = 3'(i);
      end
    end
    diff        = day_number - year_start(idx);
    ys.ok       = (day_number != 12'd0) && (day_number <= LAST_DAY);
    ys.year_idx = idx;
    ys.leap     = (idx == LEAP_IDX_A) || (idx == LEAP_IDX_B);
    ys.doy      = diff[8:0];
  end

endmodule

// ----- design/dnc_month_split.sv -----
// Day of year to ASCII year, month and day digits.
module dnc_month_split (
  input  dnc_pkg::ysplit_t ys,
  output logic [5:0]       year_char,
  output logic [5:0]       month_tens,
  output logic [5:0]       month_ones,
  output logic [5:0]       day_tens,
  output logic [5:0]       day_ones
);
  import dnc_pkg::*;

  logic [3:0] mm;
  logic [8:0] dom_full;
  logic [4:0] dom;
  logic [1:0] dt;
  logic [4:0] dof;
  logic [3:0] mo;

  always_comb begin
    mm = FIRST_MONTH;
    for (int k = 2; k < 13; k++) begin
      if (ys.doy > month_cum(ys.leap, 4'(k))) begin
        mm = 4'(k);
      end
    end
    dom_full = ys.doy - month_cum(ys.leap, mm);
    dom      = dom_full[4:0];
    priority if (dom >= 5'd30) begin
      dt = 2'd3;
    end else if (dom >= 5'd20) begin
      dt = 2'd2;
    end else if (dom >= 5'd10) begin
      dt = 2'd1;
    end else begin
      dt = 2'd0;
    end
    dof = dom - {dt, 3'b000} - {2'b00, dt, 1'b0};
    mo  = (mm >= 4'd10) ? (mm - 4'd10) : mm;
    if (ys.ok) begin
      year_char  = ASCII_ZERO + 6'd2 + {3'd0, ys.year_idx};
      month_tens = ASCII_ZERO + ((mm >= 4'd10) ? 6'd1 : 6'd0);
      month_ones = ASCII_ZERO + {2'd0, mo};
      day_tens   = ASCII_ZERO + {4'd0, dt};
      day_ones   = ASCII_ZERO + {1'b0, dof};
    end else begin
      year_char  = 6'd0;
      month_tens = 6'd0;
      month_ones = 6'd0;
      day_tens   = 6'd0;
      day_ones   = 6'd0;
    end
  end

endmodule

// ----- design/date_day_number_converter.sv -----
// Top level of the date and day number converter: input, middle and result registers.
//
//   channel   handshake        payload
//   input     start / busy     in_command, in_*_char, in_day_number
//   result    out_valid        out_day_number_out, out_*_out, out_in_range
//
// One beat is accepted per cycle whenever busy is low; busy is high only during reset.
// Each accepted beat passes the input, middle and result registers in turn; its result is shown with out_valid.
// The path is input register, then year split and encode, then month split.
// Reset clears the valid bits only; the receiver cannot stall, so nothing waits.
module date_day_number_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [7:0]  in_year_char,
  input  logic [7:0]  in_month_tens_char,
  input  logic [7:0]  in_month_ones_char,
  input  logic [7:0]  in_day_tens_char,
  input  logic [7:0]  in_day_ones_char,
  input  logic [11:0] in_day_number,
  output logic        out_valid,
  output logic [11:0] out_day_number_out,
  output logic [5:0]  out_year_char_out,
  output logic [5:0]  out_month_tens_out,
  output logic [5:0]  out_month_ones_out,
  output logic [5:0]  out_day_tens_out,
  output logic [5:0]  out_day_ones_out,
  output logic        out_in_range
);
  import dnc_pkg::*;

  logic        in_vld_r;
  logic        cmd_r;
  logic [7:0]  yc_r, mt_r, mo_r, dt_r, do_r;
  logic [11:0] dn_r;
  logic        mid_vld_r;
  mid_t        mid_r, mid_nxt;
  logic        enc_ok;
  logic [11:0] enc_days;
  ysplit_t     ys;
  logic [5:0]  d_year, d_mt, d_mo, d_dt, d_do;
  logic        accept;

  assign busy   = ~rst_n;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      mid_vld_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      in_vld_r  <= accept;
      mid_vld_r <= in_vld_r;
      out_valid <= mid_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= in_command;
    yc_r  <= in_year_char;
    mt_r  <= in_month_tens_char;
    mo_r  <= in_month_ones_char;
    dt_r  <= in_day_tens_char;
    do_r  <= in_day_ones_char;
    dn_r  <= in_day_number;
  end

  dnc_encode u_encode (
    .year_char       (yc_r),
    .month_tens_char (mt_r),
    .month_ones_char (mo_r),
    .day_tens_char   (dt_r),
    .day_ones_char   (do_r),
    .enc_ok          (enc_ok),
    .enc_days        (enc_days)
  );

  dnc_year_split u_year_split (
    .day_number (dn_r),
    .ys         (ys)
  );

  always_comb begin
    mid_nxt.cmd      = cmd_r;
    mid_nxt.enc_ok   = enc_ok;
    mid_nxt.enc_days = enc_days;
    mid_nxt.ys       = ys;
  end

  always_ff @(posedge clk) begin
    mid_r <= mid_nxt;
  end

  dnc_month_split u_month_split (
    .ys         (mid_r.ys),
    .year_char  (d_year),
    .month_tens (d_mt),
    .month_ones (d_mo),
    .day_tens   (d_dt),
    .day_ones   (d_do)
  );

  always_ff @(posedge clk) begin
    if (mid_r.cmd == CMD_DECODE) begin
      out_day_number_out <= 12'd0;
      out_year_char_out  <= d_year;
      out_month_tens_out <= d_mt;
      out_month_ones_out <= d_mo;
      out_day_tens_out   <= d_dt;
      out_day_ones_out   <= d_do;
      out_in_range       <= mid_r.ys.ok;
    end else begin
      out_day_number_out <= mid_r.enc_days;
      out_year_char_out  <= 6'd0;
      out_month_tens_out <= 6'd0;
      out_month_ones_out <= 6'd0;
      out_day_tens_out   <= 6'd0;
      out_day_ones_out   <= 6'd0;
      out_in_range       <= mid_r.enc_ok;
    end
  end

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |->
      out_day_number_out == 12'd0 && out_year_char_out == 6'd0 &&
      out_month_tens_out == 6'd0 && out_month_ones_out == 6'd0 &&
      out_day_tens_out == 6'd0 && out_day_ones_out == 6'd0)
    else $error("out of range result carries nonzero fields");

  a_month_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_year_char_out != 6'd0 |->
      (out_month_tens_out == ASCII_ZERO && out_month_ones_out != ASCII_ZERO) ||
      (out_month_tens_out == ASCII_ZERO + 6'd1 && out_month_ones_out <= ASCII_ZERO + 6'd2))
    else $error("decoded month outside 01 to 12");

  a_year_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_year_char_out != 6'd0 |->
      out_year_char_out >= ASCII_ZERO + 6'd2 && out_year_char_out <= ASCII_ZERO + 6'd8 &&
      out_day_number_out == 12'd0)
    else $error("decoded year digit outside 2 to 8");

endmodule
